>>> design/cpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_pkg: shared types and constants of the carrot path follower
// Holds the coordinate type, configuration and command/status bundles, and
// the register map used between the configuration port, controller and
// datapath.
// ----------------------------------------------------------------------------
package cpf_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);

  // Search window around the previous closest waypoint.
  localparam logic [10:0] SEARCH_BACK  = 11'd3;
  localparam logic [10:0] SEARCH_AHEAD = 11'd3;

  // Iteration counts of the shared square root and divide units.
  localparam logic [4:0] SQ_LAST  = 5'd16;  // 17 steps for a 34-bit radicand
  localparam logic [4:0] DIV_LAST = 5'd29;  // 30 steps for a 30-bit dividend

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_LAYER_LEN  = 3'd0;
  localparam logic [2:0] REG_LAYER_CNT  = 3'd1;
  localparam logic [2:0] REG_LOOKAHEAD  = 3'd2;
  localparam logic [2:0] REG_MAX_JUMP   = 3'd3;
  localparam logic [2:0] REG_START_RAD  = 3'd4;
  localparam logic [2:0] REG_FINISH_RAD = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

  typedef struct packed {
    logic [10:0] layer_length;
    logic [9:0]  layer_count;
    logic [11:0] lookahead;
    logic [11:0] max_jump;
    logic [11:0] start_rad;
    logic [11:0] finish_rad;
  } cfg_t;

  // Waypoint store address selection.
  typedef enum logic [1:0] {
    ASEL_FIRST = 2'd0,
    ASEL_IDX   = 2'd1,
    ASEL_NEXT  = 2'd2,
    ASEL_LAST  = 2'd3
  } asel_e;

  // Operand pair of the squared distance unit.
  typedef enum logic [1:0] {
    DSEL_P1_POS   = 2'd0,
    DSEL_P1_P2    = 2'd1,
    DSEL_CAR_LCAR = 2'd2,
    DSEL_LPT_POS  = 2'd3
  } dsel_e;

  typedef struct packed {
    logic        wr_pt;
    logic        start;
    logic        rd_en;
    asel_e       asel;
    logic        ld_p1;
    logic        ld_p2;
    logic        ld_lpt;
    logic        d_step;
    dsel_e       dsel;
    logic [1:0]  axis;
    logic        best_upd;
    logic        walk_init;
    logic        walk_next;
    logic        lc_clr;
    logic        sq_init;
    logic        sq_step;
    logic        div_init;
    logic        div_step;
    logic        div_fin;
    logic        car_p1;
    logic        car_lpt;
    logic        car_lcar;
    logic        car_zero;
    logic        lcar_p1;
    logic        lcar_set;
    logic        out_ld;
    logic        out_appr;
    logic        out_done;
    logic        out_all;
    logic [9:0]  layer;
  } cmd_t;

  typedef struct packed {
    logic win_more;
    logic walk_more;
    logic seg_ge;
    logic seg_zero;
    logic end_near;
    logic lt_start;
    logic gt_jump;
    logic lt_finish;
    logic out_busy;
  } sts_t;

  function automatic logic signed [15:0] axis_of(vec_t v, logic [1:0] a);
    logic signed [15:0] r;
    case (a)
      AXIS_X:  r = v.x;
      AXIS_Y:  r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/cpf_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_cfg: configuration register file
// APB-style slave holding the six follower settings.
// ----------------------------------------------------------------------------
module cpf_cfg import cpf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layer_length <= 11'd64;
      cfg_q.layer_count  <= 10'd1;
      cfg_q.lookahead    <= 12'd125;
      cfg_q.max_jump     <= 12'd225;
      cfg_q.start_rad    <= 12'd200;
      cfg_q.finish_rad   <= 12'd50;
    end else if (wr_en) begin
      case (idx)
        REG_LAYER_LEN:  cfg_q.layer_length <= pwdata[10:0];
        REG_LAYER_CNT:  cfg_q.layer_count  <= pwdata[9:0];
        REG_LOOKAHEAD:  cfg_q.lookahead    <= pwdata[11:0];
        REG_MAX_JUMP:   cfg_q.max_jump     <= pwdata[11:0];
        REG_START_RAD:  cfg_q.start_rad    <= pwdata[11:0];
        REG_FINISH_RAD: cfg_q.finish_rad   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LAYER_LEN:  prdata = {21'd0, cfg_q.layer_length};
      REG_LAYER_CNT:  prdata = {22'd0, cfg_q.layer_count};
      REG_LOOKAHEAD:  prdata = {20'd0, cfg_q.lookahead};
      REG_MAX_JUMP:   prdata = {20'd0, cfg_q.max_jump};
      REG_START_RAD:  prdata = {20'd0, cfg_q.start_rad};
      REG_FINISH_RAD: prdata = {20'd0, cfg_q.finish_rad};
      default:        prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

>>> design/cpf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_ctrl: follower sequencer
// Steps the datapath through approach, window search, arc walk, carrot
// interpolation, jump limit and finish test, and holds the layer state.
// ----------------------------------------------------------------------------
module cpf_ctrl import cpf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic op_i,
  output logic      in_stall_o,
  input  cfg_t      cfg_i,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [27:0] {
    S_IDLE  = 28'd1 << 0,
    S_CHK   = 28'd1 << 1,
    S_AP_W  = 28'd1 << 2,
    S_AP_D  = 28'd1 << 3,
    S_AP_C  = 28'd1 << 4,
    S_WIN   = 28'd1 << 5,
    S_WIN_W = 28'd1 << 6,
    S_WIN_D = 28'd1 << 7,
    S_WIN_C = 28'd1 << 8,
    S_WLK0  = 28'd1 << 9,
    S_WLK   = 28'd1 << 10,
    S_SEG_A = 28'd1 << 11,
    S_SEG_B = 28'd1 << 12,
    S_SEG_D = 28'd1 << 13,
    S_SQI   = 28'd1 << 14,
    S_SQ    = 28'd1 << 15,
    S_SEG_C = 28'd1 << 16,
    S_LRP   = 28'd1 << 17,
    S_DIV   = 28'd1 << 18,
    S_DFN   = 28'd1 << 19,
    S_LAST  = 28'd1 << 20,
    S_LST_W = 28'd1 << 21,
    S_JMP   = 28'd1 << 22,
    S_JMP_C = 28'd1 << 23,
    S_END   = 28'd1 << 24,
    S_FIN_D = 28'd1 << 25,
    S_FIN_C = 28'd1 << 26,
    S_OUT   = 28'd1 << 27
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] ax_q, ax_d;
  logic [4:0] cnt_q, cnt_d;
  logic [9:0] cur_q, cur_d;
  logic       fpr_q, fpr_d;
  logic       cv_q, cv_d;
  logic       es_q, es_d;
  logic       placed_q, placed_d;
  logic       appr_q, appr_d;
  logic       done_q, done_d;
  logic       all_done;
  logic       ax_last;

  assign all_done   = cur_q >= cfg_i.layer_count;
  assign ax_last    = ax_q == AXIS_Z;
  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ax_q     <= AXIS_X;
      cnt_q    <= 5'd0;
      cur_q    <= 10'd0;
      fpr_q    <= 1'b0;
      cv_q     <= 1'b0;
      es_q     <= 1'b0;
      placed_q <= 1'b0;
      appr_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ax_q     <= ax_d;
      cnt_q    <= cnt_d;
      cur_q    <= cur_d;
      fpr_q    <= fpr_d;
      cv_q     <= cv_d;
      es_q     <= es_d;
      placed_q <= placed_d;
      appr_q   <= appr_d;
      done_q   <= done_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    ax_d     = ax_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    fpr_d    = fpr_q;
    cv_d     = cv_q;
    es_d     = es_q;
    placed_d = placed_q;
    appr_d   = appr_q;
    done_d   = done_q;
    cmd_o          = '0;
    cmd_o.asel     = ASEL_IDX;
    cmd_o.dsel     = DSEL_P1_POS;
    cmd_o.axis     = ax_q;
    cmd_o.layer    = cur_q;
    cmd_o.out_appr = appr_q;
    cmd_o.out_done = done_q;
    cmd_o.out_all  = all_done;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!op_i) begin
            cmd_o.wr_pt = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            appr_d      = 1'b0;
            done_d      = 1'b0;
            placed_d    = 1'b0;
            state_d     = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (all_done) begin
          cmd_o.car_zero = 1'b1;
          state_d        = S_OUT;
        end else if (!fpr_q) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.asel  = ASEL_FIRST;
          state_d     = S_AP_W;
        end else begin
          state_d = S_WIN;
        end
      end
      S_AP_W: begin
        cmd_o.ld_p1 = 1'b1;
        state_d     = S_AP_D;
      end
      S_AP_D: begin
        cmd_o.d_step = 1'b1;
        cmd_o.dsel   = DSEL_P1_POS;
        ax_d         = ax_last ? AXIS_X : ax_q + 2'd1;
        if (ax_last) state_d = S_AP_C;
      end
      S_AP_C: begin
        if (sts_i.lt_start) fpr_d = 1'b1;
        cmd_o.car_p1 = 1'b1;
        cmd_o.lc_clr = 1'b1;
        if (!cv_q) begin
          cmd_o.lcar_p1 = 1'b1;
          cv_d          = 1'b1;
        end
        appr_d  = 1'b1;
        state_d = S_OUT;
      end
      S_WIN: begin
        if (sts_i.win_more) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_WIN_W;
        end else begin
          state_d = S_WLK0;
        end
      end
      S_WIN_W: begin
        cmd_o.ld_p1 = 1'b1;
        state_d     = S_WIN_D;
      end
      S_WIN_D: begin
        cmd_o.d_step = 1'b1;
        cmd_o.dsel   = DSEL_P1_POS;
        ax_d         = ax_last ? AXIS_X : ax_q + 2'd1;
        if (ax_last) state_d = S_WIN_C;
      end
      S_WIN_C: begin
        cmd_o.best_upd = 1'b1;
        state_d        = S_WIN;
      end
      S_WLK0: begin
        cmd_o.walk_init = 1'b1;
        state_d         = S_WLK;
      end
      S_WLK: begin
        if (sts_i.walk_more) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SEG_A;
        end else begin
          state_d = S_LAST;
        end
      end
      S_SEG_A: begin
        cmd_o.ld_p1 = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.asel  = ASEL_NEXT;
        state_d     = S_SEG_B;
      end
      S_SEG_B: begin
        cmd_o.ld_p2 = 1'b1;
        state_d     = S_SEG_D;
      end
      S_SEG_D: begin
        cmd_o.d_step = 1'b1;
        cmd_o.dsel   = DSEL_P1_P2;
        ax_d         = ax_last ? AXIS_X : ax_q + 2'd1;
        if (ax_last) state_d = S_SQI;
      end
      S_SQI: begin
        cmd_o.sq_init = 1'b1;
        cnt_d         = 5'd0;
        state_d       = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        cnt_d         = cnt_q + 5'd1;
        if (cnt_q == SQ_LAST) state_d = S_SEG_C;
      end
      S_SEG_C: begin
        if (sts_i.seg_ge) begin
          placed_d = 1'b1;
          if (sts_i.seg_zero) begin
            cmd_o.car_p1 = 1'b1;
            state_d      = S_LAST;
          end else begin
            ax_d    = AXIS_X;
            state_d = S_LRP;
          end
        end else begin
          cmd_o.walk_next = 1'b1;
          state_d         = S_WLK;
        end
      end
      S_LRP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = 5'd0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) state_d = S_DFN;
      end
      S_DFN: begin
        cmd_o.div_fin = 1'b1;
        if (ax_last) begin
          ax_d    = AXIS_X;
          state_d = S_LAST;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_LRP;
        end
      end
      S_LAST: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.asel  = ASEL_LAST;
        state_d     = S_LST_W;
      end
      S_LST_W: begin
        cmd_o.ld_lpt = 1'b1;
        if (!placed_q) cmd_o.car_lpt = 1'b1;
        state_d = S_JMP;
      end
      S_JMP: begin
        if (!cv_q) begin
          cv_d    = 1'b1;
          state_d = S_END;
        end else begin
          cmd_o.d_step = 1'b1;
          cmd_o.dsel   = DSEL_CAR_LCAR;
          ax_d         = ax_last ? AXIS_X : ax_q + 2'd1;
          if (ax_last) state_d = S_JMP_C;
        end
      end
      S_JMP_C: begin
        if (sts_i.gt_jump) cmd_o.car_lcar = 1'b1;
        state_d = S_END;
      end
      S_END: begin
        cmd_o.lcar_set = 1'b1;
        if (sts_i.end_near) es_d = 1'b1;
        state_d = S_FIN_D;
      end
      S_FIN_D: begin
        cmd_o.d_step = 1'b1;
        cmd_o.dsel   = DSEL_LPT_POS;
        ax_d         = ax_last ? AXIS_X : ax_q + 2'd1;
        if (ax_last) state_d = S_FIN_C;
      end
      S_FIN_C: begin
        if (es_q && sts_i.lt_finish) begin
          done_d = 1'b1;
          cur_d  = cur_q + 10'd1;
          fpr_d  = 1'b0;
          es_d   = 1'b0;
          cv_d   = 1'b0;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/cpf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_dp: follower datapath
// Waypoint store, point registers, squared distance accumulator, iterative
// square root and divider, carrot registers and the result register.
// ----------------------------------------------------------------------------
module cpf_dp import cpf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cfg_t                    cfg_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  wire logic [9:0]         point_index_i,
  input  wire logic signed [15:0] coord_x_i,
  input  wire logic signed [15:0] coord_y_i,
  input  wire logic signed [15:0] coord_z_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic signed [15:0]      carrot_x_o,
  output logic signed [15:0]      carrot_y_o,
  output logic signed [15:0]      carrot_z_o,
  output logic                    approaching_o,
  output logic                    layer_done_o,
  output logic [9:0]              active_layer_o,
  output logic                    all_done_o
);

  vec_t              mem [MAX_POINTS];
  vec_t              rd_q;
  vec_t              pos_q, p1_q, p2_q, lpt_q, car_q, lcar_q;
  logic [ADDR_W-1:0] base_q, rd_addr;
  logic [10:0]       idx_q, closest_q, lc_q;
  logic              have_q;
  logic [33:0]       acc_q, best_q;
  logic [33:0]       sv_q, sr_q, sb_q;
  logic [11:0]       rem_q;
  logic [29:0]       dn_q;
  logic [17:0]       dr_q;
  logic              neg_q;

  logic [10:0]              len, len_m1, lo, hi;
  logic [11:0]              hi_raw;
  logic [20:0]              base_prod;
  vec_t                     da, db;
  logic signed [15:0]       ax_a, ax_b;
  logic signed [16:0]       diff;
  logic signed [33:0]       sq_s;
  logic [33:0]              acc_sum;
  logic [34:0]              sq_try;
  logic [16:0]              seg;
  logic signed [16:0]       dlt;
  logic [16:0]              mag;
  logic [27:0]              prod;
  logic [17:0]              den;
  logic [18:0]              dtry;
  logic signed [16:0]       lerp_a, lerp_r;
  logic [23:0]              start_sq, jump_sq, fin_sq;

  // Layer geometry.
  assign len       = (cfg_i.layer_length < 11'd2) ? 11'd2 : cfg_i.layer_length;
  assign len_m1    = len - 11'd1;
  assign base_prod = {11'd0, cmd_i.layer} * {10'd0, len};
  assign lo        = (lc_q > SEARCH_BACK) ? lc_q - SEARCH_BACK : 11'd0;
  assign hi_raw    = {1'b0, lc_q} + {1'b0, SEARCH_AHEAD};
  assign hi        = (hi_raw > {1'b0, len_m1}) ? len_m1 : hi_raw[10:0];

  always_comb begin
    case (cmd_i.asel)
      ASEL_FIRST: rd_addr = base_q;
      ASEL_IDX:   rd_addr = base_q + idx_q[ADDR_W-1:0];
      ASEL_NEXT:  rd_addr = base_q + idx_q[ADDR_W-1:0] + 1'b1;
      default:    rd_addr = base_q + len_m1[ADDR_W-1:0];
    endcase
  end

  // Waypoint store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pt) mem[point_index_i] <= {coord_x_i, coord_y_i, coord_z_i};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem[rd_addr];
  end

  // Squared distance, one axis per cycle.
  always_comb begin
    case (cmd_i.dsel)
      DSEL_P1_POS:   begin da = p1_q;  db = pos_q;  end
      DSEL_P1_P2:    begin da = p1_q;  db = p2_q;   end
      DSEL_CAR_LCAR: begin da = car_q; db = lcar_q; end
      default:       begin da = lpt_q; db = pos_q;  end
    endcase
  end

  assign ax_a    = axis_of(da, cmd_i.axis);
  assign ax_b    = axis_of(db, cmd_i.axis);
  assign diff    = {ax_a[15], ax_a} - {ax_b[15], ax_b};
  assign sq_s    = diff * diff;
  assign acc_sum = ((cmd_i.axis == AXIS_X) ? 34'd0 : acc_q) + $unsigned(sq_s);

  // Square root and interpolation terms.
  assign sq_try = {1'b0, sr_q} + {1'b0, sb_q};
  assign seg    = sr_q[16:0];
  assign dlt    = {axis_of(p2_q, cmd_i.axis)[15], axis_of(p2_q, cmd_i.axis)}
                - {axis_of(p1_q, cmd_i.axis)[15], axis_of(p1_q, cmd_i.axis)};
  assign mag    = dlt[16] ? 17'(-dlt) : dlt;
  assign prod   = mag[15:0] * rem_q;
  assign den    = {seg, 1'b0};
  assign dtry   = {dr_q, dn_q[29]};
  assign lerp_a = {axis_of(p1_q, cmd_i.axis)[15], axis_of(p1_q, cmd_i.axis)};
  assign lerp_r = neg_q ? lerp_a - $signed(dn_q[16:0]) : lerp_a + $signed(dn_q[16:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q   <= 11'd0;
      lcar_q <= '0;
    end else begin
      if (cmd_i.lc_clr) lc_q <= 11'd0;
      else if (cmd_i.walk_init) lc_q <= closest_q;
      if (cmd_i.lcar_p1) lcar_q <= p1_q;
      else if (cmd_i.lcar_set) lcar_q <= car_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pos_q     <= {coord_x_i, coord_y_i, coord_z_i};
      base_q    <= base_prod[ADDR_W-1:0];
      idx_q     <= lo;
      closest_q <= 11'd0;
      have_q    <= 1'b0;
      rem_q     <= cfg_i.lookahead;
    end else if (cmd_i.best_upd) begin
      if (!have_q || acc_q < best_q) begin
        best_q    <= acc_q;
        closest_q <= idx_q;
      end
      have_q <= 1'b1;
      idx_q  <= idx_q + 11'd1;
    end else if (cmd_i.walk_init) begin
      idx_q <= closest_q;
    end else if (cmd_i.walk_next) begin
      rem_q <= rem_q - seg[11:0];
      idx_q <= idx_q + 11'd1;
    end
    if (cmd_i.ld_p1) p1_q <= rd_q;
    if (cmd_i.ld_p2) p2_q <= rd_q;
    if (cmd_i.ld_lpt) lpt_q <= rd_q;
    if (cmd_i.d_step) acc_q <= acc_sum;
    if (cmd_i.sq_init) begin
      sv_q <= acc_q;
      sr_q <= 34'd0;
      sb_q <= 34'd1 << 32;
    end else if (cmd_i.sq_step) begin
      if ({1'b0, sv_q} >= sq_try) begin
        sv_q <= sv_q - sq_try[33:0];
        sr_q <= (sr_q >> 1) + sb_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sb_q <= sb_q >> 2;
    end
    if (cmd_i.div_init) begin
      dn_q  <= {1'b0, prod, 1'b0} + {13'd0, seg};
      dr_q  <= 18'd0;
      neg_q <= dlt[16];
    end else if (cmd_i.div_step) begin
      if (dtry >= {1'b0, den}) begin
        dr_q <= 18'(dtry - {1'b0, den});
        dn_q <= {dn_q[28:0], 1'b1};
      end else begin
        dr_q <= dtry[17:0];
        dn_q <= {dn_q[28:0], 1'b0};
      end
    end
    if (cmd_i.car_zero) begin
      car_q <= '0;
    end else if (cmd_i.car_p1) begin
      car_q <= p1_q;
    end else if (cmd_i.car_lpt) begin
      car_q <= rd_q;
    end else if (cmd_i.car_lcar) begin
      car_q <= lcar_q;
    end else if (cmd_i.div_fin) begin
      case (cmd_i.axis)
        AXIS_X:  car_q.x <= lerp_r[15:0];
        AXIS_Y:  car_q.y <= lerp_r[15:0];
        default: car_q.z <= lerp_r[15:0];
      endcase
    end
  end

  // Radius tests against squared thresholds.
  assign start_sq = cfg_i.start_rad * cfg_i.start_rad;
  assign jump_sq  = cfg_i.max_jump * cfg_i.max_jump;
  assign fin_sq   = cfg_i.finish_rad * cfg_i.finish_rad;

  assign sts_o.win_more  = idx_q < hi;
  assign sts_o.walk_more = idx_q < len_m1;
  assign sts_o.seg_ge    = seg >= {5'd0, rem_q};
  assign sts_o.seg_zero  = seg == 17'd0;
  assign sts_o.end_near  = ({1'b0, idx_q} + 12'd2) >= {1'b0, len};
  assign sts_o.lt_start  = acc_q < {10'd0, start_sq};
  assign sts_o.gt_jump   = acc_q > {10'd0, jump_sq};
  assign sts_o.lt_finish = acc_q < {10'd0, fin_sq};
  assign sts_o.out_busy  = out_valid_o && out_stall_i;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      carrot_x_o     <= car_q.x;
      carrot_y_o     <= car_q.y;
      carrot_z_o     <= car_q.z;
      approaching_o  <= cmd_i.out_appr;
      layer_done_o   <= cmd_i.out_done;
      active_layer_o <= cmd_i.layer;
      all_done_o     <= cmd_i.out_all;
    end
  end

endmodule
`default_nettype wire

>>> design/carrot_path_follower.sv
`default_nettype none
// ----------------------------------------------------------------------------
// carrot_path_follower: layered carrot-chasing path follower
// Top level joining the configuration port, the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel carries an op. With op low it
// writes one waypoint (x, y, z in mm) into the 1024-entry store at
// point_index and produces no result. With op high it is a vehicle position
// sample and produces exactly one result transfer: the carrot position, the
// approach and layer-done flags, the active layer and the all-done flag.
// In the follow phase a position sample searches a window of W waypoints
// (up to 6) and walks S segments. Each segment costs two store reads, a
// squared distance over the three axes and a 17-step square root in the
// shared unit; placing the carrot adds a 30-step divide per axis.
// The result register sits between the sequencer and the output: a new item
// is accepted while a finished result still waits, and the sequencer only
// holds at its final step when out_stall_i keeps the earlier result in place.
// Reset clears layer state and the result valid; the waypoint store holds
// whatever was last written. Configuration is to be written through the APB
// port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module carrot_path_follower import cpf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [9:0]         point_index_i,
  input  wire logic signed [15:0] coord_x_i,
  input  wire logic signed [15:0] coord_y_i,
  input  wire logic signed [15:0] coord_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      carrot_x_o,
  output logic signed [15:0]      carrot_y_o,
  output logic signed [15:0]      carrot_z_o,
  output logic                    approaching_o,
  output logic                    layer_done_o,
  output logic [9:0]              active_layer_o,
  output logic                    all_done_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Register file for the follower settings.
  cpf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: owns the layer state and issues one command word per cycle.
  cpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: store, arithmetic units and the result register.
  cpf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .point_index_i  (point_index_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .carrot_x_o     (carrot_x_o),
    .carrot_y_o     (carrot_y_o),
    .carrot_z_o     (carrot_z_o),
    .approaching_o  (approaching_o),
    .layer_done_o   (layer_done_o),
    .active_layer_o (active_layer_o),
    .all_done_o     (all_done_o)
  );

endmodule
`default_nettype wire
